// ===== rtl/core/sspc_pkg.sv =====
// ----------------------------------------------------------------------------
// sspc_pkg : shared types and constants of the servo status packet checker
// Function codes, status codes, the fixed byte values of a status reply and the idle-tick limits.
// ----------------------------------------------------------------------------
`default_nettype none

package sspc_pkg;

   typedef logic [1:0]  func_type;
   typedef logic [2:0]  status_type;

   localparam func_type FUNC_START = 2'd0;
   localparam func_type FUNC_BYTE  = 2'd1;
   localparam func_type FUNC_TICK  = 2'd2;

   localparam status_type ST_OK       = 3'd0;
   localparam status_type ST_TIMEOUT  = 3'd1;
   localparam status_type ST_HEADER   = 3'd2;
   localparam status_type ST_ID       = 3'd3;
   localparam status_type ST_LENGTH   = 3'd4;
   localparam status_type ST_CHECKSUM = 3'd5;

   localparam logic [7:0]  HDR_BYTE    = 8'hFF;
   localparam logic [7:0]  BCAST_ID    = 8'hFE;
   localparam logic [7:0]  READ_ALL    = 8'd255;
   localparam logic [7:0]  SUM_GOOD    = 8'hFF;
   localparam logic [15:0] LIMIT_RESET = 16'd5000;
   localparam logic [15:0] IDLE_MAX    = 16'hFFFF;

endpackage

`default_nettype wire

// ===== rtl/core/servo_status_packet_checker.sv =====
// A transaction passes through the input register, then the packet state update
// and the result register.
// Throughput: one transaction per cycle; the result register and the input
// register stall together only when rsp_tready holds a result back.
// Reset (synchronous, active high) idles the checker, clears all packet state
// and sets the timeout limit to 5000 idle ticks.
// ----------------------------------------------------------------------------
// servo_status_packet_checker
// Checks a servo status reply byte by byte and reports status, the returned
// length and parameter bytes 5 and 6 when the packet ends.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_status_packet_checker
   import sspc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // rx_byte, expected_len, sent_id
   input  wire logic [1:0]  req_tuser,   // func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // returned_length, param_low, param_high
   output logic [2:0]       rsp_tuser    // status
);

   // input register
   logic       in_valid_ff;
   func_type   in_func_ff;
   logic [7:0] in_byte_ff, in_len_ff, in_id_ff;

   // packet state
   logic [15:0] limit_ff;
   logic        busy_ff, busy_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  target_ff, target_in;
   logic [7:0]  exp_id_ff, exp_id_in;
   logic [7:0]  sum_ff, sum_in;
   logic        hdr_good_ff, hdr_good_in;
   logic        id_good_ff, id_good_in;
   logic [7:0]  len_byte_ff, len_byte_in;
   logic [7:0]  param_lo_ff, param_lo_in;
   logic [7:0]  param_hi_ff, param_hi_in;
   logic [15:0] idle_ff, idle_in;

   // result register
   logic        out_valid_ff;
   status_type  out_status_ff, status_in;
   logic [7:0]  out_len_ff, rlen_in;
   logic [7:0]  out_plo_ff, out_phi_ff;

   logic advance, take, fin, timed;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign take       = in_valid_ff && advance;

   always_comb begin
      busy_in     = busy_ff;
      count_in    = count_ff;
      target_in   = target_ff;
      exp_id_in   = exp_id_ff;
      sum_in      = sum_ff;
      hdr_good_in = hdr_good_ff;
      id_good_in  = id_good_ff;
      len_byte_in = len_byte_ff;
      param_lo_in = param_lo_ff;
      param_hi_in = param_hi_ff;
      idle_in     = idle_ff;
      fin         = 1'b0;
      timed       = 1'b0;
      if (take) begin
         case (in_func_ff)
            FUNC_START: begin
               busy_in     = 1'b1;
               count_in    = 8'd0;
               target_in   = in_len_ff;
               exp_id_in   = in_id_ff;
               sum_in      = 8'd0;
               hdr_good_in = 1'b1;
               id_good_in  = 1'b1;
               len_byte_in = 8'd0;
               idle_in     = 16'd0;
               fin         = (in_len_ff == 8'd0);
            end
            FUNC_BYTE: begin
               if (busy_ff) begin
                  if (count_ff < 8'd2 && in_byte_ff != HDR_BYTE) hdr_good_in = 1'b0;
                  if (count_ff == 8'd2) id_good_in = (in_byte_ff == exp_id_ff);
                  if (count_ff >= 8'd2) sum_in = sum_ff + in_byte_ff;
                  if (count_ff == 8'd3) len_byte_in = in_byte_ff;
                  if (count_ff == 8'd5) param_lo_in = in_byte_ff;
                  if (count_ff == 8'd6) param_hi_in = in_byte_ff;
                  count_in = count_ff + 8'd1;
                  idle_in  = 16'd0;
                  fin      = (count_in == target_ff);
               end
            end
            FUNC_TICK: begin
               if (busy_ff) begin
                  if (idle_ff != IDLE_MAX) idle_in = idle_ff + 16'd1;
                  if (idle_in > limit_ff) begin
                     fin   = 1'b1;
                     timed = 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
      if (fin) busy_in = 1'b0;

      // checks in priority order, from the updated packet state
      status_in = ST_OK;
      if (exp_id_in != BCAST_ID) begin
         if (timed && target_in != READ_ALL)           status_in = ST_TIMEOUT;
         else if (count_in > 8'd3) begin
            if (!hdr_good_in)                           status_in = ST_HEADER;
            else if (!id_good_in)                       status_in = ST_ID;
            else if (len_byte_in != count_in - 8'd4)    status_in = ST_LENGTH;
            else if (sum_in != SUM_GOOD)                status_in = ST_CHECKSUM;
         end
      end
      rlen_in = (status_in == ST_OK) ? count_in : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         limit_ff     <= LIMIT_RESET;
         busy_ff      <= 1'b0;
         count_ff     <= 8'd0;
         target_ff    <= 8'd0;
         exp_id_ff    <= 8'd0;
         sum_ff       <= 8'd0;
         hdr_good_ff  <= 1'b1;
         id_good_ff   <= 1'b1;
         len_byte_ff  <= 8'd0;
         param_lo_ff  <= 8'd0;
         param_hi_ff  <= 8'd0;
         idle_ff      <= 16'd0;
      end else begin
         if (csr_we) limit_ff <= csr_wdata;
         if (req_tready) in_valid_ff <= req_tvalid;
         if (advance) out_valid_ff <= fin;
         busy_ff     <= busy_in;
         count_ff    <= count_in;
         target_ff   <= target_in;
         exp_id_ff   <= exp_id_in;
         sum_ff      <= sum_in;
         hdr_good_ff <= hdr_good_in;
         id_good_ff  <= id_good_in;
         len_byte_ff <= len_byte_in;
         param_lo_ff <= param_lo_in;
         param_hi_ff <= param_hi_in;
         idle_ff     <= idle_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_func_ff <= req_tuser;
         in_byte_ff <= req_tdata[7:0];
         in_len_ff  <= req_tdata[15:8];
         in_id_ff   <= req_tdata[23:16];
      end
      if (fin) begin
         out_status_ff <= status_in;
         out_len_ff    <= rlen_in;
         out_plo_ff    <= param_lo_in;
         out_phi_ff    <= param_hi_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = {out_phi_ff, out_plo_ff, out_len_ff};

endmodule

`default_nettype wire

// ===== rtl/core/sspc_checker.sv =====
// ----------------------------------------------------------------------------
// sspc_checker : port-level assertions for servo_status_packet_checker
// Watches the result channel over time; bound to servo_status_packet_checker.
// ----------------------------------------------------------------------------
`default_nettype none

module sspc_checker
   import sspc_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic [2:0]  rsp_tuser
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= ST_CHECKSUM)
      else $error("status code out of range");

   a_err_len_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tdata[7:0] == 8'd0)
      else $error("error result reports a nonzero length");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind servo_status_packet_checker sspc_checker u_sspc_checker (.*);

`default_nettype wire

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top : self-checking bench for servo_status_packet_checker
// Streams start, byte and idle-tick transactions into the checker, predicts
// the verdict of every status reply in a scoreboard and compares it, field by
// field, with each transaction taken from the result stream. Both sides add
// random gaps; the timeout limit is changed between drained phases.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import sspc_pkg::*;

   localparam int          RANDOM_ITEMS  = 1100;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          CYCLE_LIMIT   = 1_000_000;
   localparam int          HOLD_CYCLES   = 200;
   localparam logic [15:0] LIMIT_LOW     = 16'd1;
   localparam logic [15:0] LIMIT_TOP     = 16'hFFFE;
   localparam func_type    FUNC_UNUSED   = 2'd3;

   typedef enum int {FAULT_NONE, FAULT_HEADER, FAULT_ID, FAULT_LENGTH, FAULT_SUM,
                     FAULT_ANY} fault_type;

   typedef struct packed {
      status_type status;
      logic [7:0] length;
      logic [7:0] param_lo;
      logic [7:0] param_hi;
   } verdict_type;

   class verdict_scoreboard;
      logic [15:0] limit;
      bit          busy;
      logic [7:0]  count, target, want_id, sum, len_byte, param_lo, param_hi;
      bit          hdr_ok, id_ok;
      logic [15:0] idle_ticks;
      verdict_type verdicts_due[$];
      int          errors;
      int          items_used;

      function new();
         limit      = LIMIT_RESET;
         busy       = 1'b0;
         count      = 8'h00;
         target     = 8'h00;
         want_id    = 8'h00;
         sum        = 8'h00;
         len_byte   = 8'h00;
         param_lo   = 8'h00;
         param_hi   = 8'h00;
         hdr_ok     = 1'b1;
         id_ok      = 1'b1;
         idle_ticks = 16'h0000;
         errors     = 0;
         items_used = 0;
      endfunction

      function void set_limit(logic [15:0] value);
         limit = value;
      endfunction

      function void report(string what);
         errors++;
         if (errors <= 10) $display("mismatch at %0t: %s", $time, what);
      endfunction

      function void close_packet(bit timed_out);
         status_type  st;
         verdict_type v;
         st   = ST_OK;
         busy = 1'b0;
         if (want_id != BCAST_ID) begin
            if (timed_out && target != READ_ALL) begin
               st = ST_TIMEOUT;
            end else if (count > 8'd3) begin
               if (!hdr_ok)                        st = ST_HEADER;
               else if (!id_ok)                    st = ST_ID;
               else if (len_byte != count - 8'd4)  st = ST_LENGTH;
               else if (sum != SUM_GOOD)           st = ST_CHECKSUM;
            end
         end
         v.status   = st;
         v.length   = (st == ST_OK) ? count : 8'h00;
         v.param_lo = param_lo;
         v.param_hi = param_hi;
         verdicts_due.push_back(v);
      endfunction

      function void note_request(func_type f, logic [7:0] rx, logic [7:0] len,
                                 logic [7:0] id);
         case (f)
            FUNC_START: begin
               items_used++;
               busy       = 1'b1;
               count      = 8'h00;
               target     = len;
               want_id    = id;
               sum        = 8'h00;
               hdr_ok     = 1'b1;
               id_ok      = 1'b1;
               len_byte   = 8'h00;
               idle_ticks = 16'h0000;
               if (target == 8'h00) close_packet(1'b0);
            end
            FUNC_BYTE: if (busy) begin
               items_used++;
               if (count < 8'd2 && rx != HDR_BYTE) hdr_ok = 1'b0;
               if (count == 8'd2) id_ok = (rx == want_id);
               if (count >= 8'd2) sum = sum + rx;
               if (count == 8'd3) len_byte = rx;
               if (count == 8'd5) param_lo = rx;
               if (count == 8'd6) param_hi = rx;
               count      = count + 8'd1;
               idle_ticks = 16'h0000;
               if (count == target) close_packet(1'b0);
            end
            FUNC_TICK: if (busy) begin
               items_used++;
               if (idle_ticks != IDLE_MAX) idle_ticks = idle_ticks + 16'd1;
               if (idle_ticks > limit) close_packet(1'b1);
            end
            default: ;
         endcase
      endfunction

      function void check_verdict(status_type st, logic [23:0] data);
         verdict_type want;
         if (verdicts_due.size() == 0) begin
            report($sformatf("unexpected result status %0d data %h", st, data));
            return;
         end
         want = verdicts_due.pop_front();
         if (st !== want.status || data[7:0] !== want.length
             || data[15:8] !== want.param_lo || data[23:16] !== want.param_hi)
            report($sformatf("expected status %0d len %0d params %h %h, got %0d %0d %h %h",
                             want.status, want.length, want.param_lo, want.param_hi,
                             st, data[7:0], data[15:8], data[23:16]));
      endfunction
   endclass

   logic        clock;
   logic        reset      = 1'b1;
   logic        csr_we     = 1'b0;
   logic [15:0] csr_wdata  = 16'h0000;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = 24'h000000;
   logic [1:0]  req_tuser  = 2'b00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   bit                req_gaps = 1'b1;
   bit                rsp_gaps = 1'b1;
   int                rsp_hold = 0;
   int                cycles   = 0;
   logic [7:0]        reply_bytes[$];
   verdict_scoreboard sb = new();

   servo_status_packet_checker uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAIL servo_status_packet_checker");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_request(func_type'(req_tuser), req_tdata[7:0], req_tdata[15:8],
                            req_tdata[23:16]);
         if (rsp_tvalid && rsp_tready)
            sb.check_verdict(status_type'(rsp_tuser), rsp_tdata);
      end
   end

   // result side: random stall per transaction, or one long hold when asked
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold != 0) begin
            stall    = rsp_hold;
            rsp_hold = 0;
         end else begin
            stall = rsp_gaps ? $urandom_range(0, 9) : 0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic drive_item(input func_type f, input logic [7:0] rx = 8'h00,
                             input logic [7:0] len = 8'h00, input logic [7:0] id = 8'h00);
      int gap;
      gap = req_gaps ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tuser  <= f;
      req_tdata  <= {id, len, rx};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // drop valid and wait out every verdict plus the pipeline
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.verdicts_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.set_limit(value);
   endtask

   // build a well-formed status reply of n bytes, then break one byte if asked
   function automatic void make_reply(int n, logic [7:0] id, fault_type fault);
      logic [7:0] acc;
      logic [7:0] v;
      int         spot;
      acc = 8'h00;
      reply_bytes.delete();
      for (int i = 0; i < n; i++) begin
         if (i < 2)           v = HDR_BYTE;
         else if (i == 2)     v = id;
         else if (i == 3)     v = 8'(n - 4);
         else if (i == n - 1) v = SUM_GOOD - acc;
         else                 v = 8'($urandom);
         if (i >= 2) acc = acc + v;
         reply_bytes.push_back(v);
      end
      case (fault)
         FAULT_HEADER: spot = $urandom_range(0, 1);
         FAULT_ID:     spot = 2;
         FAULT_LENGTH: spot = 3;
         FAULT_SUM:    spot = n - 1;
         FAULT_ANY:    spot = $urandom_range(0, (n > 0) ? n - 1 : 0);
         default:      spot = -1;
      endcase
      if (spot >= 0 && spot < n) reply_bytes[spot] ^= 8'($urandom_range(1, 255));
   endfunction

   task automatic run_reply(input logic [7:0] target, input logic [7:0] id, input int ticks);
      drive_item(FUNC_START, 8'($urandom), target, id);
      foreach (reply_bytes[i]) begin
         if ($urandom_range(0, 15) == 0)
            drive_item(FUNC_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
         drive_item(FUNC_BYTE, reply_bytes[i], 8'($urandom), 8'($urandom));
      end
      repeat (ticks) drive_item(FUNC_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   initial begin
      int          base, n, kind, ticks, phase;
      fault_type   fault;
      logic [7:0]  target, id;
      logic [15:0] limit;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: idle traffic, zero length, restart, read-all, broadcast
      write_limit(LIMIT_LOW);
      drive_item(FUNC_BYTE, HDR_BYTE);
      drive_item(FUNC_TICK);
      drive_item(FUNC_UNUSED, 8'hFF, 8'hFF, 8'hFF);
      drive_item(FUNC_START, 8'h00, 8'h00, 8'h00);
      drive_item(FUNC_START, 8'h00, 8'd10, BCAST_ID);
      drive_item(FUNC_START, 8'h00, READ_ALL, 8'hFF);
      drive_item(FUNC_BYTE, HDR_BYTE);
      drive_item(FUNC_BYTE, HDR_BYTE);
      drive_item(FUNC_BYTE, 8'hFF);
      drive_item(FUNC_BYTE, 8'h00);
      drive_item(FUNC_TICK);
      drive_item(FUNC_TICK);
      drive_item(FUNC_START, 8'h00, 8'd2, BCAST_ID);
      drive_item(FUNC_BYTE, 8'h00);
      drive_item(FUNC_BYTE, 8'h00);
      make_reply(7, 8'h03, FAULT_NONE);
      run_reply(8'd7, 8'h03, 0);
      drive_item(FUNC_START, 8'h00, 8'd20, 8'h01);
      drive_item(FUNC_BYTE, HDR_BYTE);
      drive_item(FUNC_TICK);
      drive_item(FUNC_TICK);
      settle();

      base  = sb.items_used;
      phase = 0;
      while (sb.items_used - base < RANDOM_ITEMS) begin
         case (phase % 4)
            0:       limit = LIMIT_LOW;
            1:       limit = 16'($urandom_range(2, 12));
            2:       limit = 16'($urandom_range(13, 40));
            default: limit = LIMIT_TOP;
         endcase
         write_limit(limit);
         req_gaps = ($urandom_range(0, 3) != 0);
         rsp_gaps = ($urandom_range(0, 3) != 0);
         if (phase == 1) begin
            // hold the result side while one-byte replies back up into the input
            rsp_hold = HOLD_CYCLES;
            req_gaps = 1'b0;
            repeat (30) begin
               drive_item(FUNC_START, 8'($urandom), 8'd1, 8'($urandom));
               drive_item(FUNC_BYTE, 8'($urandom), 8'($urandom), 8'($urandom));
            end
            req_gaps = ($urandom_range(0, 3) != 0);
         end
         repeat (15) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 60) : $urandom_range(4, 12);
            if ($urandom_range(0, 49) == 0) n = 255;
            id    = ($urandom_range(0, 7) == 0) ? BCAST_ID : 8'($urandom);
            fault = ($urandom_range(0, 3) == 0) ?
                    fault_type'($urandom_range(FAULT_HEADER, FAULT_ANY)) : FAULT_NONE;
            make_reply(n, id, fault);
            kind   = $urandom_range(0, 99);
            ticks  = $urandom_range(0, 2);
            target = 8'(n);
            if (kind < 15) begin
               target = READ_ALL;
               if (limit <= 16'd40) ticks = int'(limit) + 1;
               run_reply(target, id, ticks);
            end else if (kind < 25) begin
               target = (n >= 250) ? 8'd254 : 8'(n + $urandom_range(1, 4));
               if (limit <= 16'd40) ticks = int'(limit) + 1;
               run_reply(target, id, ticks);
            end else if (kind < 35) begin
               // cut the reply short; the next start drops it
               while (reply_bytes.size() > 0 && $urandom_range(0, 2) != 0)
                  void'(reply_bytes.pop_back());
               run_reply(target, id, 0);
            end else if (kind < 45) begin
               repeat ($urandom_range(1, 6))
                  drive_item(func_type'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                             8'($urandom));
            end else begin
               run_reply(target, id, ticks);
            end
         end
         settle();
         phase++;
      end

      req_tvalid <= 1'b0;
      for (int i = 0; i < 10000 && sb.verdicts_due.size() != 0; i++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.verdicts_due.size() != 0)
         sb.report($sformatf("%0d verdicts never arrived", sb.verdicts_due.size()));
      if (sb.errors == 0)
         $display("PASS servo_status_packet_checker");
      else
         $display("FAIL servo_status_packet_checker");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/sspc_pkg.sv
rtl/core/servo_status_packet_checker.sv
rtl/core/sspc_checker.sv
verif/tb_top.sv
